// File: rtl/etmc_pkg.sv
package etmc_pkg;

   // task modes, also the reported state code
   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_AWAITING  = 3'd1,
      MODE_SAVING    = 3'd2,
      MODE_FOLLOWING = 3'd3,
      MODE_WAITING   = 3'd4,
      MODE_SEARCHING = 3'd5
   } mode_type;

   // mobility commands
   typedef enum logic [1:0] {
      MOB_NONE   = 2'd0,
      MOB_STOP   = 2'd1,
      MOB_FOLLOW = 2'd2,
      MOB_SEARCH = 2'd3
   } mob_type;

   localparam logic [3:0] NO_USER      = 4'd0;
   localparam logic [1:0] TMPL_NONE    = 2'd1;
   localparam logic [1:0] TMPL_PRESENT = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_WAIT_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_SEARCH_LIMIT = 2'd1;
   localparam logic [1:0] CSR_MAX_DIST     = 2'd2;

   localparam int LIMIT_W = 22;
   localparam int DIST_W  = 16;
   localparam int REQ_W   = 39;
   localparam int RSP_W   = 13;

   // reset values of the configuration registers
   localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST   = 22'd5000;
   localparam logic [LIMIT_W-1:0] SEARCH_LIMIT_RST = 22'd10000;
   localparam logic [DIST_W-1:0]  MAX_DIST_RST     = 16'd2000;

   // one update tick, last field in the lowest bits
   typedef struct packed {
      logic [DIST_W-1:0] user_distance;
      logic [1:0]        template_status;
      logic              pose_seen;
      logic [3:0]        user_id;
      logic [15:0]       elapsed_ms;
   } req_type;

   // one result, last field in the lowest bits
   typedef struct packed {
      logic     state_changed;
      logic     sensor_work;
      logic     save_template;
      logic     clear_user;
      logic     reset_calibration;
      logic     begin_calibration;
      logic     sensor_off;
      logic     clear_template;
      mob_type  mobility_command;
      mode_type task_state;
   } rsp_type;

   typedef struct packed {
      logic [DIST_W-1:0]  max_user_distance;
      logic [LIMIT_W-1:0] search_time_limit;
      logic [LIMIT_W-1:0] wait_time_limit;
   } cfg_type;

endpackage

// File: rtl/etmc_step.sv
module etmc_step #(
   parameter int TIMER_BITS = 32
) (
   input  etmc_pkg::mode_type        mode,
   input  logic [TIMER_BITS-1:0]     timer,
   input  etmc_pkg::req_type         req,
   input  etmc_pkg::cfg_type         cfg,
   output etmc_pkg::mode_type        next_mode,
   output logic [TIMER_BITS-1:0]     next_timer,
   output etmc_pkg::rsp_type         rsp
);
   import etmc_pkg::*;

   localparam int CMP_W = (TIMER_BITS + 1 > LIMIT_W) ? TIMER_BITS + 1 : LIMIT_W;

   logic [TIMER_BITS:0]   sum;
   logic [TIMER_BITS-1:0] sat;
   logic [TIMER_BITS-1:0] cur_timer;
   logic [CMP_W-1:0]      timer_x;
   logic [CMP_W-1:0]      timer_x2;
   logic [CMP_W-1:0]      wait_x;
   logic [CMP_W-1:0]      search_x;
   logic                  has_user;
   logic                  give_up;
   logic                  search_done;

   // saturating timer add
   assign sum = {1'b0, timer} + (TIMER_BITS + 1)'(req.elapsed_ms);
   assign sat = sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
   assign cur_timer = (mode == MODE_WAITING || mode == MODE_SEARCHING) ? sat : timer;

   // limit compares, half wait when the user was near
   assign timer_x  = CMP_W'(cur_timer);
   assign timer_x2 = CMP_W'({cur_timer, 1'b0});
   assign wait_x   = CMP_W'(cfg.wait_time_limit);
   assign search_x = CMP_W'(cfg.search_time_limit);
   assign give_up  = (req.user_distance > cfg.max_user_distance) ?
                     (timer_x >= wait_x) : (timer_x2 >= wait_x);
   assign search_done = timer_x >= search_x;
   assign has_user    = req.user_id != NO_USER;

   // mode transitions and entry commands
   always_comb begin
      rsp        = '0;
      next_mode  = mode;
      next_timer = cur_timer;
      unique case (mode)
         MODE_AWAITING: begin
            if (has_user) begin
               next_mode         = MODE_SAVING;
               rsp.save_template = 1'b1;
            end
         end
         MODE_SAVING: begin
            if (req.template_status == TMPL_NONE) begin
               next_mode             = MODE_AWAITING;
               rsp.reset_calibration = 1'b1;
               rsp.clear_user        = 1'b1;
            end else if (req.template_status == TMPL_PRESENT) begin
               next_mode            = MODE_FOLLOWING;
               rsp.mobility_command = MOB_FOLLOW;
               rsp.sensor_work      = 1'b1;
            end
         end
         MODE_FOLLOWING: begin
            if (has_user && req.pose_seen) begin
               next_mode             = MODE_AWAITING;
               rsp.mobility_command  = MOB_STOP;
               rsp.clear_template    = 1'b1;
               rsp.clear_user        = 1'b1;
               rsp.sensor_off        = 1'b1;
               rsp.begin_calibration = 1'b1;
            end else if (!has_user) begin
               next_mode            = MODE_WAITING;
               next_timer           = '0;
               rsp.mobility_command = MOB_STOP;
            end
         end
         MODE_WAITING: begin
            if (has_user) begin
               next_mode            = MODE_FOLLOWING;
               rsp.mobility_command = MOB_FOLLOW;
            end else if (give_up) begin
               next_mode            = MODE_SEARCHING;
               next_timer           = '0;
               rsp.mobility_command = MOB_SEARCH;
            end
         end
         MODE_SEARCHING: begin
            if (!has_user && search_done) begin
               next_mode             = MODE_AWAITING;
               rsp.mobility_command  = MOB_STOP;
               rsp.clear_template    = 1'b1;
               rsp.clear_user        = 1'b1;
               rsp.sensor_off        = 1'b1;
               rsp.begin_calibration = 1'b1;
            end else if (has_user) begin
               next_mode            = MODE_FOLLOWING;
               rsp.mobility_command = MOB_FOLLOW;
            end
         end
         default: begin
            // idle and unused codes hold and issue nothing
         end
      endcase
      rsp.task_state    = next_mode;
      rsp.state_changed = next_mode != mode;
   end

endmodule

// File: rtl/escort_task_mode_controller.sv
// Mode controller for a person-following robot. Each req word is one update
// tick; each tick gives exactly one rsp word with the mode after the tick and
// the one-shot commands issued on entering it. A tick passes an input register,
// the combinational mode and timer logic, and a result register: the rsp word is
// valid once the tick has moved from the input register into the result register,
// and one tick is accepted every cycle while rsp_tready is high. Limits are to be
// written through the csr port while no tick is in flight; the block does not enforce this.
module escort_task_mode_controller #(
   parameter int TIMER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // elapsed_ms[15:0], user_id[19:16], pose_seen[20], template_status[22:21],
   // user_distance[38:23], zero[39]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // task_state[2:0], mobility_command[4:3], clear_template[5], sensor_off[6],
   // begin_calibration[7], reset_calibration[8], clear_user[9],
   // save_template[10], sensor_work[11], state_changed[12], zero[15:13]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   import etmc_pkg::*;

   logic                  in_vld_ff;
   req_type               in_data_ff;
   logic                  out_vld_ff;
   rsp_type               out_data_ff;
   mode_type              mode_ff;
   mode_type              mode_in;
   logic [TIMER_BITS-1:0] timer_ff;
   logic [TIMER_BITS-1:0] timer_in;
   cfg_type               cfg_ff;
   rsp_type               step_rsp;
   logic                  fire;

   // a tick moves on when the result register is free or being emptied
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_data_ff};

   etmc_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .mode       (mode_ff),
      .timer      (timer_ff),
      .req        (in_data_ff),
      .cfg        (cfg_ff),
      .next_mode  (mode_in),
      .next_timer (timer_in),
      .rsp        (step_rsp)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         mode_ff    <= MODE_AWAITING;
         timer_ff   <= '0;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (fire) begin
            out_vld_ff <= 1'b1;
            mode_ff    <= mode_in;
            timer_ff   <= timer_in;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_type'(req_tdata[REQ_W-1:0]);
      end
      if (fire) begin
         out_data_ff <= step_rsp;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_time_limit   <= WAIT_LIMIT_RST;
         cfg_ff.search_time_limit <= SEARCH_LIMIT_RST;
         cfg_ff.max_user_distance <= MAX_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WAIT_LIMIT:   cfg_ff.wait_time_limit   <= csr_wdata;
            CSR_SEARCH_LIMIT: cfg_ff.search_time_limit <= csr_wdata;
            CSR_MAX_DIST:     cfg_ff.max_user_distance <= csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a new result reports the mode after the tick, as held in the mode register
   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_tdata[2:0] == mode_ff))
      else $error("result state differs from mode register");

   // commands only come with a transition
   a_cmd_needs_change: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_data_ff.state_changed) |->
         (out_data_ff.mobility_command == MOB_NONE && out_data_ff[11:5] == '0))
      else $error("command issued without a transition");

   // a held tick behind a stalled result blocks new input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are full");

   // the timer is cleared on entering waiting
   a_wait_timer_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && mode_ff == MODE_FOLLOWING && mode_in == MODE_WAITING) |=>
         (timer_ff == '0))
      else $error("timer not cleared on entering waiting");

endmodule
